// ===== design/slg_pkg.sv =====
// ---------------------------------------------------------------------------
// slg_pkg: shared constants and table builder for the sRGB-to-gray datapath
// Holds the fixed constants of the lightness math and the elaboration-time
// function that builds the sRGB linearization table exactly.
// ---------------------------------------------------------------------------
package slg_pkg;

  // width of the big integers used while building the table
  localparam int unsigned BigW = 384;

  // (1 + 0.055) * 255 * 1000 scaled denominator of the gamma curve
  localparam logic [31:0] LinDen = 32'd269025;

  // CIE lightness constants
  localparam logic [14:0] DarkNum  = 15'd24389;    // 24389 (kappa numerator)
  localparam logic [7:0]  DarkLim  = 8'd216;       // 216 (epsilon numerator)
  localparam logic [22:0] DarkMul  = 23'd6219195;  // 24389 * 255
  localparam logic [18:0] DarkRcp  = 19'd397683;   // ceil(2^30 / 2700)
  localparam int unsigned DarkSh   = 30;
  localparam logic [6:0]  LStarMul = 7'd116;
  localparam logic [4:0]  LStarOff = 5'd16;
  localparam logic [12:0] PctRcp   = 13'd5243;     // ceil(2^19 / 100)
  localparam int unsigned PctSh    = 19;
  localparam logic [7:0]  GrayMax  = 8'd255;

  // Linearized sRGB code c in Q0.f, rounded to nearest (ties up).
  // Gamma branch: largest n with (2n-1)^5 * den^12 <= 2^(5(f+1)) * num^12.
  function automatic logic [31:0] lin_entry(input int unsigned c, input int unsigned f);
    logic [63:0]     num;
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] qpow;
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] fac;
    logic [31:0]     lo;
    logic [31:0]     hi;
    logic [31:0]     mid;
    logic [31:0]     p;
    int              k;
    if (c <= 10) begin
      // linear toe: c / 255 / 12.92
      num = (64'(c) * 64'd100) << f;
      return 32'((64'd2 * num + 64'd329460) / 64'd658920);
    end
    p = 32'(1000 * c + 14025);
    rhs = BigW'(1);
    for (k = 0; k < 12; k++) begin
      rhs = rhs * BigW'(p);
    end
    rhs = rhs << (5 * (f + 1));
    qpow = BigW'(1);
    for (k = 0; k < 12; k++) begin
      qpow = qpow * BigW'(LinDen);
    end
    lo = 32'd0;
    hi = 32'd1 << f;
    while (lo < hi) begin
      mid = (lo + hi + 32'd1) >> 1;
      fac = BigW'(32'd2 * mid - 32'd1);
      lhs = qpow;
      for (k = 0; k < 5; k++) begin
        lhs = lhs * fac;
      end
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    return lo;
  endfunction

endpackage

// ===== design/srgb_to_lightness_gray.sv =====
// gray_o/done_o show an item once start_i is taken and it has passed the pipeline.
//   Throughput: one item per cycle, busy_o stays low.
// The depth is set by the cube root, which resolves one root bit per stage
//   (FRAC_BITS + 1 stages), plus table, multiply, sum, dark-path and scaling stages.
// Reset clears all valid bits; items in flight are dropped. The receiver cannot stall.
// ---------------------------------------------------------------------------
// srgb_to_lightness_gray: sRGB pixel to gray level through CIE lightness L*
// Linearizes each channel from a constant table, forms luminance Y, takes
// L* by the dark-region line or by a pipelined exact cube root, and scales
// L* from 0..100 to 0..255 with truncation.
// ---------------------------------------------------------------------------
module srgb_to_lightness_gray #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       done_o,
  output logic [7:0] gray_o
);

  // widths
  localparam int unsigned TW  = FRAC_BITS + 1;       // table entry, Y, root
  localparam int unsigned KW  = FRAC_BITS;           // luminance coefficients
  localparam int unsigned PW  = KW + TW;             // one weighted channel
  localparam int unsigned SW  = PW + 2;              // sum of three
  localparam int unsigned YFW = SW - FRAC_BITS;      // Y before clamp
  localparam int unsigned NS  = FRAC_BITS + 1;       // cube root stages
  localparam int unsigned SQW = 2 * FRAC_BITS + 2;   // root squared
  localparam int unsigned RW  = 2 * FRAC_BITS + 7;   // cube root remainder
  localparam int unsigned XW  = 3 * NS;              // radicand, padded
  localparam int unsigned DW  = TW + 7;              // 116*r - 16
  localparam int unsigned DMW = TW + 23;             // Y * 24389 * 255
  localparam int unsigned CMW = TW + 15;             // Y * 24389

  // fixed-point constants
  localparam logic [63:0]     One64  = 64'd1 << FRAC_BITS;
  localparam logic [KW-1:0]   KRed   = KW'((64'd2126 * One64 + 64'd5000) / 64'd10000);
  localparam logic [KW-1:0]   KGreen = KW'((64'd7152 * One64 + 64'd5000) / 64'd10000);
  localparam logic [KW-1:0]   KBlue  = KW'((64'd722 * One64 + 64'd5000) / 64'd10000);
  localparam logic [SW-1:0]   Half   = SW'(One64 >> 1);
  localparam logic [YFW-1:0]  OneY   = YFW'(One64);
  localparam logic [CMW-1:0]  DarkLimF = CMW'(64'(slg_pkg::DarkLim) << FRAC_BITS);
  localparam logic [DW-1:0]   OffF   = DW'(64'(slg_pkg::LStarOff) << FRAC_BITS);

  // linearization table, built at elaboration
  logic [TW-1:0] lin_tab [256];
  for (genvar c = 0; c < 256; c++) begin : g_lin
    localparam logic [31:0] Ent = slg_pkg::lin_entry(c, FRAC_BITS);
    assign lin_tab[c] = Ent[TW-1:0];
  end

  // pipeline registers
  logic          v1_q, v2_q, v3_q, v4_q, va_q, vb_q, done_q;
  logic [NS:0]   cv_q;
  logic [TW-1:0] tr_q, tg_q, tb_q;
  logic [PW-1:0] pr_q, pg_q, pb_q;
  logic [TW-1:0] y3_q, y4_q;
  logic          dark4_q;
  logic [15:0]   dk4_q;
  logic [TW-1:0] cy_q    [0:NS];
  logic          cdark_q [0:NS];
  logic [4:0]    cdg_q   [0:NS];
  logic [TW-1:0] rt_q    [1:NS];
  logic [SQW-1:0] sq_q   [1:NS];
  logic [RW-1:0] rm_q    [1:NS];
  logic [DW-1:0] da_q;
  logic          darka_q, darkb_q;
  logic [4:0]    dga_q, dgb_q;
  logic [14:0]   tb15_q;
  logic [7:0]    gray_q;

  // combinational stage logic
  logic [SW-1:0]  sum_d;
  logic [YFW-1:0] yfull_d;
  logic [TW-1:0]  y_d;
  logic [DMW-1:0] dmul_d;
  logic [CMW-1:0] dcmp_d;
  logic [34:0]    dgp_d;
  logic [DW-1:0]  a_d;
  logic [DW-1:0]  d_d;
  logic [DW+7:0]  tp_d;
  logic [27:0]    gp_d;
  logic [8:0]     g_d;
  logic [7:0]     gray_d;

  assign busy_o = 1'b0;

  // luminance sum with rounding, clamped to one
  always_comb begin
    sum_d   = SW'(pr_q) + SW'(pg_q) + SW'(pb_q) + Half;
    yfull_d = sum_d[SW-1:FRAC_BITS];
    y_d     = (yfull_d > OneY) ? TW'(OneY) : yfull_d[TW-1:0];
  end

  // dark region: branch test, Y*24389*255 / 2^F and its quotient by 2700
  always_comb begin
    dmul_d = DMW'(y3_q) * DMW'(slg_pkg::DarkMul);
    dcmp_d = CMW'(y3_q) * CMW'(slg_pkg::DarkNum);
    dgp_d  = 35'(dk4_q) * 35'(slg_pkg::DarkRcp);
  end

  // cube root: one root bit per stage, squares kept incrementally
  for (genvar k = 0; k < NS; k++) begin : g_cbrt
    logic [TW-1:0]  rt_in;
    logic [SQW-1:0] sq_in;
    logic [RW-1:0]  rm_in;
    logic [XW-1:0]  x;
    logic [2:0]     grp;
    logic [TW-1:0]  y2;
    logic [SQW-1:0] s2;
    logic [RW-1:0]  sy;
    logic [RW-1:0]  bsub;
    logic [RW-1:0]  r3;
    logic           take;

    if (k == 0) begin : g_first
      assign rt_in = '0;
      assign sq_in = '0;
      assign rm_in = '0;
    end else begin : g_next
      assign rt_in = rt_q[k];
      assign sq_in = sq_q[k];
      assign rm_in = rm_q[k];
    end

    // radicand is Y * 2^(2F), taken three bits at a time from the top
    assign x    = {2'b00, cy_q[k], {(2 * FRAC_BITS){1'b0}}};
    assign grp  = x[XW-1-3*k -: 3];
    assign y2   = {rt_in[TW-2:0], 1'b0};
    assign s2   = {sq_in[SQW-3:0], 2'b00};
    assign sy   = RW'(s2) + RW'(y2);
    assign bsub = (sy << 1) + sy + RW'(1);
    assign r3   = {rm_in[RW-4:0], grp};
    assign take = (r3 >= bsub);

    always_ff @(posedge clk_i) begin
      cy_q[k+1]    <= cy_q[k];
      cdark_q[k+1] <= cdark_q[k];
      cdg_q[k+1]   <= cdg_q[k];
      if (take) begin
        rt_q[k+1] <= y2 + TW'(1);
        sq_q[k+1] <= s2 + (SQW'(y2) << 1) + SQW'(1);
        rm_q[k+1] <= r3 - bsub;
      end else begin
        rt_q[k+1] <= y2;
        sq_q[k+1] <= s2;
        rm_q[k+1] <= r3;
      end
    end
  end

  // L* scaling: (116*r - 16) * 255 / 100, truncated, then saturation or dark pick
  always_comb begin
    a_d    = DW'(rt_q[NS]) * DW'(slg_pkg::LStarMul);
    d_d    = (a_d > OffF) ? (a_d - OffF) : '0;
    tp_d   = (DW+8)'(da_q) * (DW+8)'(slg_pkg::GrayMax);
    gp_d   = 28'(tb15_q) * 28'(slg_pkg::PctRcp);
    g_d    = gp_d[slg_pkg::PctSh +: 9];
    gray_d = darkb_q ? 8'(dgb_q)
                     : ((g_d > 9'(slg_pkg::GrayMax)) ? slg_pkg::GrayMax : g_d[7:0]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      cv_q   <= '0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      cv_q   <= {cv_q[NS-1:0], v4_q};
      va_q   <= cv_q[NS];
      vb_q   <= va_q;
      done_q <= vb_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    // table lookup
    tr_q <= lin_tab[red_i];
    tg_q <= lin_tab[green_i];
    tb_q <= lin_tab[blue_i];
    // weighted channels
    pr_q <= PW'(KRed) * PW'(tr_q);
    pg_q <= PW'(KGreen) * PW'(tg_q);
    pb_q <= PW'(KBlue) * PW'(tb_q);
    // luminance
    y3_q <= y_d;
    // dark branch test and scaled product
    y4_q    <= y3_q;
    dark4_q <= (dcmp_d <= DarkLimF);
    dk4_q   <= dmul_d[FRAC_BITS +: 16];
    // dark gray level, enters the cube root pipe
    cy_q[0]    <= y4_q;
    cdark_q[0] <= dark4_q;
    cdg_q[0]   <= dgp_d[slg_pkg::DarkSh +: 5];
    // lightness offset
    da_q    <= d_d;
    darka_q <= cdark_q[NS];
    dga_q   <= cdg_q[NS];
    // times 255 over 2^F
    tb15_q  <= tp_d[FRAC_BITS +: 15];
    darkb_q <= darka_q;
    dgb_q   <= dga_q;
    // final pick and saturation
    gray_q  <= gray_d;
  end

  assign done_o = done_q;
  assign gray_o = gray_q;

endmodule
